// ----- sv/tccs_pkg.sv -----
// Shared types and constants for the text console cursor/scroll block.
package tccs_pkg;

  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CELL_W     = 16;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Item kinds carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused kind, cursor report only

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

  localparam logic [7:0]        ATTR_WHITE = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_BLANK = 16'h0F20;
  localparam logic [CELL_W-1:0] CELL_EMPTY = 16'h0F00;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic copy_step;
    logic fill_step;
    logic blank_step;
    logic cnt_inc;
    logic cnt_clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              scroll_need;
    logic              cnt_copy_end;
    logic              cnt_last;
    logic              out_free;
  } status_t;

endpackage

// ----- sv/tccs_ctrl.sv -----
// Sequencer: input handshake and step control for puts, scrolls, clears and reads.
module tccs_ctrl
  import tccs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_INIT: begin
        // power-up blanking sweep
        cmd.blank_step = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        case (sts.mode)
          MODE_PUT:   state_nxt = sts.scroll_need ? ST_COPY : ST_RESULT;
          MODE_CLEAR: state_nxt = ST_CLEAR;
          default:    state_nxt = ST_RESULT;
        endcase
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.cnt_copy_end) begin
          state_nxt = ST_FILL;  // counter already sits on the last row
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.blank_step = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

// ----- sv/tccs_dp.sv -----
// Datapath: screen store, cursor, sweep counter, item and result registers.
module tccs_dp
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  cmd_t                  cmd,
  output status_t               sts
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  localparam logic [COL_W:0]    COLS_V    = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0]    ROWS_V    = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

  logic [CELL_W-1:0] cells_r [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;

  logic [MODE_W-1:0] mode_r;
  logic [CHAR_W-1:0] char_r;
  logic [IDX_W-1:0]  idx_r;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [COL_W:0]    col_inc, col_tab, col_sum;
  logic [ROW_W:0]    row_inc;
  logic              is_ctrl_char;
  logic              scroll_need;
  logic [CELL_W-1:0] cell_out;

  assign col_inc      = {1'b0, col_r} + (COL_W+1)'(1);
  assign col_sum      = {1'b0, col_r} + (COL_W+1)'(4);
  assign col_tab      = {col_sum[COL_W:2], 2'b00};
  assign row_inc      = {1'b0, row_r} + (ROW_W+1)'(1);
  assign is_ctrl_char = (char_r == CH_NEWLINE) || (char_r == CH_RETURN) ||
                        (char_r == CH_TAB);

  // cursor update for a put or a clear (clear homes it); row wraps past the bottom trigger a scroll
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    scrolled_nxt = scrolled_r;
    scroll_need  = 1'b0;
    if (cmd.load_item) begin
      scrolled_nxt = 1'b0;
    end
    if (cmd.exec) begin
      case (mode_r)
        MODE_PUT: begin
          logic row_step;
          row_step = 1'b0;
          if (char_r == CH_NEWLINE) begin
            col_nxt  = '0;
            row_step = 1'b1;
          end else if (char_r == CH_RETURN) begin
            col_nxt = '0;
          end else if (char_r == CH_TAB) begin
            if (col_tab >= COLS_V) begin
              col_nxt  = '0;
              row_step = 1'b1;
            end else begin
              col_nxt = col_tab[COL_W-1:0];
            end
          end else begin
            if (col_inc >= COLS_V) begin
              col_nxt  = '0;
              row_step = 1'b1;
            end else begin
              col_nxt = col_inc[COL_W-1:0];
            end
          end
          if (row_step) begin
            if (row_inc >= ROWS_V) begin
              scroll_need  = 1'b1;
              scrolled_nxt = 1'b1;
              row_nxt      = LAST_ROW;
            end else begin
              row_nxt = row_inc[ROW_W-1:0];
            end
          end
        end
        MODE_CLEAR: begin
          row_nxt = '0;
          col_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // store port steering
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt_r;
    raddr = cnt_r + COLS_A;
    wdata = CELL_BLANK;
    if (cmd.exec && (mode_r == MODE_PUT) && !is_ctrl_char) begin
      we    = 1'b1;
      waddr = ADDR_W'(row_r) * COLS_A + ADDR_W'(col_r);
      wdata = {ATTR_WHITE, char_r};
    end
    if (cmd.exec && (mode_r == MODE_READ)) begin
      re    = 1'b1;
      raddr = ADDR_W'(idx_r);
    end
    if (cmd.copy_step) begin
      // read one row ahead, write back the cell fetched last cycle
      re    = (cnt_r != COPY_END);
      we    = (cnt_r != '0);
      waddr = cnt_r - ADDR_W'(1);
      wdata = rd_data_r;
    end
    if (cmd.fill_step) begin
      we    = 1'b1;
      wdata = CELL_EMPTY;
    end
    if (cmd.blank_step) begin
      we    = 1'b1;
      wdata = CELL_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= cells_r[raddr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end
  end

  always_comb begin
    cell_out = '0;
    if ((mode_r == MODE_READ) && (int'(idx_r) < CELL_COUNT)) begin
      cell_out = rd_data_r;
    end
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = {3'b000, scrolled_r, OUT_COL_W'(col_r), OUT_ROW_W'(row_r), cell_out};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      scrolled_r   <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      mode_r       <= MODE_PUT;
    end else begin
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      scrolled_r   <= scrolled_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cmd.load_item) begin
        mode_r <= in_tuser;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (cmd.load_item) begin
      char_r <= in_tdata[CHAR_W-1:0];
      idx_r  <= in_tdata[CHAR_W +: IDX_W];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign sts.mode         = mode_r;
  assign sts.scroll_need  = scroll_need;
  assign sts.cnt_copy_end = (cnt_r == COPY_END);
  assign sts.cnt_last     = (cnt_r == LAST_CELL);
  assign sts.out_free     = !out_tvalid_r || out_tready;

endmodule

// ----- sv/text_console_cursor_scroll.sv -----
// Top level of the character-cell text console with cursor and scrolling.
//
// Usage: one item in on the in_ stream, one result out on the out_ stream.
//   in_tuser selects the item: put character, clear screen or read one cell.
//   Every item yields exactly one result transfer with the cursor after it.
// Item paths: put without scroll, read and unused kind run execute then result;
//   a put that scrolls adds the row-copy walk and the bottom-row fill,
//   and a clear adds the blanking sweep over the screen store.
// The scroll cost is the row-copy walk over the screen store (one read, one write
//   port): one cell moved per cycle, then the freed bottom row filled one cell a cycle.
// A short item passes the accept, execute and result states in turn.
// One item is in flight at a time; in_tready is high only while idle.
// Reset: cursor goes home and a blanking pass writes every cell with the
//   blank pattern, with in_tready low, before the first transfer is taken.
// Stall: the result sits in an output register until taken; a finished item
//   waits there, and the next item is taken once the sequencer returns idle.
module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // cell_data[15:0], pos_row[20:16],
                                            // pos_col[27:21], scrolled[28], zero pad
);

  cmd_t    cmd;
  status_t sts;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // one item at a time: the cycle after a transfer in, nothing more is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in flight");

  // a scrolling put leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |-> (out_tdata[20:16] == OUT_ROW_W'(ROWS - 1)))
    else $error("scroll reported with cursor off the last row");

  // reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((int'(out_tdata[27:21]) < COLUMNS) && (int'(out_tdata[20:16]) < ROWS)))
    else $error("cursor outside the screen");

endmodule

// ----- verif/text_console_cursor_scroll_tb.sv -----
// Self-checking testbench for the text console: driver, monitor and cell-store predictor.
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb
  import tccs_pkg::*;
();

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int ITEM_TARGET = 1950;
  // Longest legal quiet stretch: reset blanking pass, a receiver hold-off,
  // a scroll walk and idle draws; taken several times.
  localparam int QUIET_LIMIT = 12000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    logic [MODE_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    bit                wait_drain;  // hold this item until every report is back
  } console_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [OUT_ROW_W-1:0] pos_row;
    logic [OUT_COL_W-1:0] pos_col;
    logic                 scrolled;
  } console_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // char_code[7:0], cell_index[18:8], zero pad
  logic [MODE_W-1:0]     in_tuser = '0;   // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // cell_data[15:0], pos_row[20:16],
                                          // pos_col[27:21], scrolled[28], zero pad

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the screen store and the cursor
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int                model_row;
  int                model_col;

  console_item_t     items_to_send[$];
  console_report_t   console_reports_due[$];
  int                fail_count = 0;
  int                n_sent = 0;     // input transfers taken
  int                n_recv = 0;     // result transfers taken
  int                quiet_cycles = 0;

  // Blank every cell and home the cursor: reset state and the clear command.
  task automatic blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = CELL_BLANK;
    model_row = 0;
    model_col = 0;
  endtask

  // Apply one accepted item to the model and queue the report it must produce.
  task automatic apply_console_item(input console_item_t it);
    console_report_t rep;
    rep = '0;
    case (it.kind)
      MODE_PUT: begin
        if (it.char_code == CH_NEWLINE) begin
          model_row++;
          model_col = 0;
        end else if (it.char_code == CH_RETURN) begin
          model_col = 0;
        end else if (it.char_code == CH_TAB) begin
          model_col = (model_col + 4) & ~3;
          if (model_col >= COLUMNS) begin
            model_col = 0;
            model_row++;
          end
        end else begin
          screen_model[model_row * COLUMNS + model_col] = {ATTR_WHITE, it.char_code};
          model_col++;
          if (model_col >= COLUMNS) begin
            model_col = 0;
            model_row++;
          end
        end
        // past the bottom: shift rows up, open an empty last row
        if (model_row >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = CELL_EMPTY;
          model_row    = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      MODE_CLEAR: blank_screen();
      MODE_READ: begin
        if (it.cell_index < CELL_COUNT) rep.cell_data = screen_model[it.cell_index];
      end
      default: ;  // unused kind: cursor report only
    endcase
    rep.pos_row = OUT_ROW_W'(model_row);
    rep.pos_col = OUT_COL_W'(model_col);
    console_reports_due.push_back(rep);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  int live_items = 0;  // items that do something (unused kind not counted)

  function automatic void add_item(input logic [MODE_W-1:0] kind, input int code,
                                   input int index, input bit drain = 1'b0);
    console_item_t it;
    it.kind       = kind;
    it.char_code  = CHAR_W'(code);
    it.cell_index = IDX_W'(index);
    it.wait_drain = drain;
    items_to_send.push_back(it);
    if (kind != MODE_SPARE) live_items++;
  endfunction

  // Mostly printable text, now and then any byte at all.
  function automatic int text_byte();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(8'h20, 8'h7E);
  endfunction

  function automatic int any_index();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 2047);  // past the end too
    return $urandom_range(0, CELL_COUNT - 1);
  endfunction

  // Bottom row, where scrolls leave their marks.
  function automatic int model_index_hint();
    return (ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1);
  endfunction

  task automatic build_stimulus();
    int pick;
    int n;
    bit drain;
    // directed: store after reset, read edges and out-of-range indexes
    add_item(MODE_READ, 0, 0, 1'b1);
    add_item(MODE_READ, 0, CELL_COUNT - 1);
    add_item(MODE_READ, 0, CELL_COUNT);
    add_item(MODE_READ, 8'hFF, 2047);
    // puts including bytes with the top bit set, the zero byte and control characters
    add_item(MODE_PUT, 8'h41, 0);
    add_item(MODE_PUT, 8'h80, 0);
    add_item(MODE_PUT, 8'hFF, 2047);
    add_item(MODE_PUT, 8'h00, 0);
    add_item(MODE_PUT, int'(CH_TAB), 0);
    add_item(MODE_PUT, 8'h7E, 0);
    add_item(MODE_PUT, int'(CH_RETURN), 0);
    add_item(MODE_PUT, int'(CH_NEWLINE), 0);
    add_item(MODE_PUT, int'(CH_TAB), 0);
    // unused kind with every data bit set, then with none
    add_item(MODE_SPARE, 8'hFF, 2047);
    add_item(MODE_SPARE, 8'h00, 0);
    add_item(MODE_READ, 0, 0);
    add_item(MODE_READ, 0, 1);
    add_item(MODE_READ, 0, 3);
    add_item(MODE_READ, 0, COLUMNS);
    add_item(MODE_CLEAR, 8'hFF, 2047);
    add_item(MODE_READ, 0, 0);
    add_item(MODE_READ, 0, 1);

    // random: whole lines of text, raw byte runs, tab runs, read bursts, noise, rare clears
    while (live_items < ITEM_TARGET) begin
      pick  = $urandom_range(0, 99);
      drain = ($urandom_range(0, 15) == 0);
      if (pick < 48) begin
        // short line ending in newline, sometimes CR first
        n = $urandom_range(0, 30);
        add_item(MODE_PUT, text_byte(), 0, drain);
        for (int i = 0; i < n; i++) add_item(MODE_PUT, text_byte(), 0);
        if ($urandom_range(0, 7) == 0) add_item(MODE_PUT, int'(CH_RETURN), 0);
        add_item(MODE_PUT, int'(CH_NEWLINE), 0);
      end else if (pick < 60) begin
        // long run of raw bytes, may wrap at the line end one or more times
        n = $urandom_range(60, 170);
        for (int i = 0; i < n; i++)
          add_item(MODE_PUT, $urandom_range(0, 255), 0, drain && i == 0);
      end else if (pick < 67) begin
        // tab run that can reach the line end and wrap
        n = $urandom_range(18, 22);
        for (int i = 0; i < n; i++) add_item(MODE_PUT, int'(CH_TAB), 0, drain && i == 0);
        add_item(MODE_PUT, text_byte(), 0);
      end else if (pick < 83) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) add_item(MODE_READ, $urandom_range(0, 255), any_index(),
                                             drain && i == 0);
      end else if (pick < 97) begin
        // noise: any kind, any data
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          add_item(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                   $urandom_range(0, 2047), drain && i == 0);
      end else if (pick < 99) begin
        add_item(MODE_PUT, text_byte(), 0, drain);
        add_item(MODE_READ, 0, model_index_hint());
      end else begin
        add_item(MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047), drain);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, run control
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    blank_screen();
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // sample at the falling edge, clear of the clocked processes
    while (items_to_send.size() != 0 || in_tvalid) @(negedge clk);
    while (n_sent != n_recv || console_reports_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && console_reports_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: too long with no transfer on either side means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents items from the queue with random gaps between them
  // ---------------------------------------------------------------------------
  console_item_t cur_item;
  bit            in_fire;
  bit            drained;
  bit            send_calm = 1'b0;  // gapless stretch
  int            send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        apply_console_item(cur_item);
        n_sent <= n_sent + 1;
        if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 17);
      end
      if (in_fire || !in_tvalid) begin
        // everything sent so far has come back, counting this edge's transfers
        drained = (n_sent + int'(in_fire)) == (n_recv + int'(out_tvalid && out_tready));
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (items_to_send.size() != 0 &&
                     (!items_to_send[0].wait_drain || drained)) begin
          cur_item  = items_to_send.pop_front();
          in_tuser  <= cur_item.kind;
          in_tdata  <= {5'b0, cur_item.cell_index, cur_item.char_code};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, two long hold-offs, field-by-field check
  // ---------------------------------------------------------------------------
  console_report_t want;
  bit              recv_calm = 1'b0;
  int              recv_stall = 0;
  int              hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (console_reports_due.size() == 0) begin
          $error("result transfer with no item outstanding: out_tdata 0x%0h", out_tdata);
          fail_count++;
        end else begin
          want = console_reports_due.pop_front();
          check_field("cell_data", want.cell_data, out_tdata[15:0]);
          check_field("pos_row", want.pos_row, out_tdata[20:16]);
          check_field("pos_col", want.pos_col, out_tdata[27:21]);
          check_field("scrolled", want.scrolled, out_tdata[28]);
        end
        n_recv <= n_recv + 1;
        if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 17);
        // long hold-off while the sender keeps offering: block fills and stalls
        if (n_recv == 499 || n_recv == 1499) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule
